>>> design/vms_pkg.sv
// Package for the plane von Mises stress stream: field widths and stream bus widths.
// Used by von_mises_stress_stream; depends on nothing else.
package vms_pkg;

    // Width of each stress field as it sits in the input stream data.
    localparam int FIELD_BITS = 32;

    // Width of the equivalent stress field in the output stream data.
    localparam int OUT_BITS = 33;

    // Stream data widths, padded up to whole bytes.
    localparam int S_TDATA_BITS = 3 * FIELD_BITS;
    localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // Bit offsets of the stress fields inside the input stream data.
    localparam int XX_LSB = 0;
    localparam int YY_LSB = FIELD_BITS;
    localparam int XY_LSB = 2 * FIELD_BITS;

endpackage

>>> design/von_mises_stress_stream.sv
// Plane von Mises equivalent stress, one element per cycle unless the pipeline is held, as a deep pipeline.
// Depends on vms_pkg for field widths and stream bus widths.
//
//  Channel  | Direction | Payload (lowest bit first)                  | Marker
//  s_axis   | in        | normal_xx, normal_yy, shear_xy (Q16.16)     | tlast = last_element
//  m_axis   | out       | equivalent_stress (33b, Q17.16), zero pad   | tlast = last_result
//
// One transaction enters the pipeline per cycle while it is not held;
// each passes through STRESS_WIDTH + 5 register stages.
// The depth is set by the square root, which resolves one result bit per pipeline stage.
// The whole pipeline advances whenever the output register is empty or being taken.
// A one-entry skid register on the input keeps the input ready a registered signal.
// Reset clears only the valid bits; payload registers are not reset.
module von_mises_stress_stream #(
    parameter int STRESS_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream. tdata: normal_xx [31:0], normal_yy [63:32], shear_xy [95:64].
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [vms_pkg::S_TDATA_BITS-1:0]   i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // Output stream. tdata: equivalent_stress [32:0], zero pad [39:33].
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [vms_pkg::M_TDATA_BITS-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    localparam int W      = STRESS_WIDTH;
    localparam int PROD_W = 2 * W;
    localparam int SUM_W  = 2 * W + 2;
    localparam int ROOT_W = W + 1;
    localparam int REM_W  = ROOT_W + 2;

    // Pipeline enable: everything moves when the output register can move.
    logic w_en;
    assign w_en = !o_m_axis_tvalid || i_m_axis_tready;

    // Input skid register.
    logic                            r_skid_valid;
    logic [vms_pkg::S_TDATA_BITS-1:0] r_skid_data;
    logic                            r_skid_last;
    logic                            w_accept;

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
        if (!w_en && w_accept) begin
            r_skid_data <= i_s_axis_tdata;
            r_skid_last <= i_s_axis_tlast;
        end
    end

    // Source of the next pipeline entry: the skid register first, else the port.
    logic                            w_src_valid;
    logic [vms_pkg::S_TDATA_BITS-1:0] w_src_data;
    logic                            w_src_last;

    assign w_src_valid = r_skid_valid || w_accept;
    assign w_src_data  = r_skid_valid ? r_skid_data : i_s_axis_tdata;
    assign w_src_last  = r_skid_valid ? r_skid_last : i_s_axis_tlast;

    // Stage 0: take the low STRESS_WIDTH bits of each field as two's complement.
    logic                 r_v0;
    logic                 r_l0;
    logic signed [W-1:0]  r_x0;
    logic signed [W-1:0]  r_y0;
    logic signed [W-1:0]  r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= w_src_valid;
        end
        if (w_en) begin
            r_l0 <= w_src_last;
            r_x0 <= $signed(w_src_data[vms_pkg::XX_LSB +: W]);
            r_y0 <= $signed(w_src_data[vms_pkg::YY_LSB +: W]);
            r_s0 <= $signed(w_src_data[vms_pkg::XY_LSB +: W]);
        end
    end

    // Stage 1: the four products, each in its own multiplier.
    logic                     r_v1;
    logic                     r_l1;
    logic signed [PROD_W-1:0] r_pxx;
    logic signed [PROD_W-1:0] r_pyy;
    logic signed [PROD_W-1:0] r_pxy;
    logic signed [PROD_W-1:0] r_pss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= r_v0;
        end
        if (w_en) begin
            r_l1  <= r_l0;
            r_pxx <= r_x0 * r_x0;
            r_pyy <= r_y0 * r_y0;
            r_pxy <= r_x0 * r_y0;
            r_pss <= r_s0 * r_s0;
        end
    end

    // Stage 2: two partial sums, squares of normals and the shear term less the cross term.
    logic                    r_v2;
    logic                    r_l2;
    logic signed [SUM_W-1:0] r_sum_a;
    logic signed [SUM_W-1:0] r_sum_b;
    logic signed [SUM_W-1:0] w_pss_ext;

    assign w_pss_ext = SUM_W'(r_pss);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
        if (w_en) begin
            r_l2    <= r_l1;
            r_sum_a <= SUM_W'(r_pxx) + SUM_W'(r_pyy);
            r_sum_b <= (w_pss_ext <<< 1) + w_pss_ext - SUM_W'(r_pxy);
        end
    end

    // Square root: restoring, one result bit per stage. Entry 0 holds the full sum.
    logic                 r_sq_v    [0:ROOT_W];
    logic                 r_sq_l    [0:ROOT_W];
    logic [SUM_W-1:0]     r_sq_rad  [0:ROOT_W];
    logic [REM_W-1:0]     r_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]    r_sq_root [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r_v2;
        end
        if (w_en) begin
            r_sq_l[0]    <= r_l2;
            r_sq_rad[0]  <= SUM_W'(r_sum_a + r_sum_b);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W-1:0] w_rem_sh;
        logic [REM_W-1:0] w_trial;
        logic             w_fits;

        // Bring down the next two radicand bits and try the next root bit.
        assign w_rem_sh = {r_sq_rem[k][REM_W-3:0], r_sq_rad[k][SUM_W-1 -: 2]};
        assign w_trial  = {r_sq_root[k], 2'b01};
        assign w_fits   = w_rem_sh >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            if (w_en) begin
                r_sq_l[k+1]    <= r_sq_l[k];
                r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
                r_sq_rem[k+1]  <= w_fits ? (w_rem_sh - w_trial) : w_rem_sh;
                r_sq_root[k+1] <= {r_sq_root[k][ROOT_W-2:0], w_fits};
            end
        end
    end

    // The last root stage is the output register.
    assign o_m_axis_tvalid = r_sq_v[ROOT_W];
    assign o_m_axis_tlast  = r_sq_l[ROOT_W];
    assign o_m_axis_tdata  = vms_pkg::M_TDATA_BITS'(vms_pkg::OUT_BITS'(r_sq_root[ROOT_W]));

    // The skid register only fills while the pipeline is held.
    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(!w_en))
        else $error("skid register filled while the pipeline was moving");

    // A held transaction leaves the skid register as soon as the pipeline moves.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_en |=> !r_skid_valid)
        else $error("skid register not drained on pipeline advance");

    // An accepted transaction on a moving pipeline lands in stage 0.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_en |=> r_v0)
        else $error("accepted transaction did not enter the pipeline");

    // The final remainder of a valid root never exceeds twice the root.
    a_root_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_sq_rem[ROOT_W] <= REM_W'({r_sq_root[ROOT_W], 1'b0})))
        else $error("square root remainder out of range");

endmodule
